// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/bpa_pkg.sv -----
// Types and constants of the battery percent averager.
// No dependencies; used by all RTL modules of the block.
package bpa_pkg;

    localparam int RAW_W     = 12;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = 19;   // (4095 * 100) fits in 19 bits
    localparam int QUO_STEPS = 7;    // quotients never exceed 100
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [PCT_W-1:0]     PCT_FULL    = 7'd100;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RAW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RAW = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_UPDATE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_FINISH,
        ST_TMO_WAIT
    } state_t;

    typedef struct packed {
        logic capture;    // latch raw sample
        logic mul;        // clamp and scale by 100
        logic pct_go;     // start percent division
        logic pct_latch;  // store sample percent
        logic update;     // write ring, update running sum
        logic avg_go;     // start mean division
        logic avg_latch;  // store averaged level
        logic load_res;   // load full result into output register
        logic load_tmo;   // load timeout result into output register
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ----- hw/rtl/bpa_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 7-bit quotient.
// Depends on bpa_pkg.
module bpa_div
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [RAW_W-1:0]  divisor,
    output logic [PCT_W-1:0]  quo,
    output logic              done
);

    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [RAW_W-1:0]  dvs_reg, dvs_next;
    logic [PCT_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] trial;

    assign trial = PROD_W'(dvs_reg) << step_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dvs_next  = divisor;
            quo_next  = '0;
            step_next = STEP_W'(QUO_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next           = rem_reg - trial;
                quo_next[step_reg] = 1'b1;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/bpa_datapath.sv -----
// Datapath: config registers, scaling, ring memory, running sum, output register.
// Depends on bpa_pkg and bpa_div.
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [RAW_W-1:0]     sample_in,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [RAW_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PCT_W-1:0]     out_level,
    output logic [PCT_W-1:0]     out_sample,
    output logic                 out_updated
);

    localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int WARM_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = $clog2(100 * HISTORY_DEPTH + 1);

    logic [RAW_W-1:0]  min_reg, max_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [RAW_W-1:0]  span_reg, span_next;
    logic [PCT_W-1:0]  pct_reg;
    logic [PCT_W-1:0]  avg_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WARM_W-1:0] warm_reg, warm_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PCT_W-1:0]  old_reg;
    logic [PCT_W-1:0]  hist_mem [HISTORY_DEPTH];

    logic              out_valid_reg, out_valid_next;
    logic [PCT_W-1:0]  out_level_reg, out_sample_reg;
    logic              out_upd_reg;

    logic [RAW_W-1:0]  clamped;
    logic              span_ok;
    logic              warm_full;
    logic              div_start;
    logic [PROD_W-1:0] div_dividend;
    logic [RAW_W-1:0]  div_divisor;
    logic [PCT_W-1:0]  div_quo;
    logic              div_done;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_RAW: min_reg <= cfg_data;
                REG_MAX_RAW: max_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // clamp and scale; an empty or inverted span gives 0 / 1
    always_comb
    begin
        span_ok = max_reg > min_reg;
        if (raw_reg > max_reg)
            clamped = max_reg;
        else if (raw_reg < min_reg)
            clamped = min_reg;
        else
            clamped = raw_reg;
        if (span_ok)
        begin
            prod_next = PROD_W'(clamped - min_reg) * PROD_W'(PCT_FULL);
            span_next = max_reg - min_reg;
        end
        else
        begin
            prod_next = '0;
            span_next = RAW_W'(1);
        end
    end

    assign div_start    = cmd.pct_go | cmd.avg_go;
    assign div_dividend = cmd.avg_go ? PROD_W'(sum_reg) : prod_reg;
    assign div_divisor  = cmd.avg_go ? RAW_W'(warm_reg) : span_reg;

    bpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quo      (div_quo),
        .done     (div_done)
    );

    // while warming up the slot being written holds no sample yet (the ring has no reset)
    assign warm_full = warm_reg == WARM_W'(HISTORY_DEPTH);

    always_comb
    begin
        idx_next  = idx_reg;
        warm_next = warm_reg;
        sum_next  = sum_reg;
        if (cmd.update)
        begin
            idx_next = (idx_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
            if (warm_full)
            begin
                sum_next = SUM_W'(({1'b0, sum_reg} + (SUM_W + 1)'(pct_reg))
                                  - (SUM_W + 1)'(old_reg));
            end
            else
            begin
                warm_next = warm_reg + 1'b1;
                sum_next  = SUM_W'({1'b0, sum_reg} + (SUM_W + 1)'(pct_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            warm_reg <= '0;
            sum_reg  <= '0;
            avg_reg  <= PCT_FULL;
        end
        else
        begin
            idx_reg  <= idx_next;
            warm_reg <= warm_next;
            sum_reg  <= sum_next;
            if (cmd.avg_latch)
                avg_reg <= div_quo;
        end
    end

    // ring memory, registered read of the slot about to be overwritten
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            hist_mem[idx_reg] <= pct_reg;
        old_reg <= hist_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            raw_reg <= sample_in;
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            span_reg <= span_next;
        end
        if (cmd.pct_latch)
            pct_reg <= div_quo;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_res || cmd.load_tmo)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            out_level_reg  <= avg_reg;
            out_sample_reg <= pct_reg;
            out_upd_reg    <= 1'b1;
        end
        else if (cmd.load_tmo)
        begin
            out_level_reg  <= avg_reg;
            out_sample_reg <= '0;
            out_upd_reg    <= 1'b0;
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_level   = out_level_reg;
    assign out_sample  = out_sample_reg;
    assign out_updated = out_upd_reg;

endmodule

// ----- hw/rtl/bpa_ctrl.sv -----
// Controller state machine sequencing scale, divide, ring update and output.
// Depends on bpa_pkg.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_timeout,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   accept;

    // a result waiting in the output register does not hold off the next request
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !in_timeout)
                    state_next = ST_MUL;
                else if (accept && in_timeout && !sts.out_free)
                    state_next = ST_TMO_WAIT;
            end
            ST_MUL:      state_next = ST_PCT_GO;
            ST_PCT_GO:   state_next = ST_PCT_WAIT;
            ST_PCT_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:   state_next = ST_AVG_GO;
            ST_AVG_GO:   state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            ST_TMO_WAIT:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture  = accept && !in_timeout;
                cmd.load_tmo = accept && in_timeout && sts.out_free;
            end
            ST_MUL:      cmd.mul       = 1'b1;
            ST_PCT_GO:   cmd.pct_go    = 1'b1;
            ST_PCT_WAIT: cmd.pct_latch = sts.div_done;
            ST_UPDATE:   cmd.update    = 1'b1;
            ST_AVG_GO:   cmd.avg_go    = 1'b1;
            ST_AVG_WAIT: cmd.avg_latch = sts.div_done;
            ST_FINISH:   cmd.load_res  = sts.out_free;
            ST_TMO_WAIT: cmd.load_tmo  = sts.out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/battery_percent_averager_unit.sv -----
// Battery percent averager, top level.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath, bpa_div and assert_macros.svh.
//
// Input stream: one request per ADC reading; s_tdata carries the 12-bit sample,
// s_tuser flags a conversion timeout. Output stream: one result per request
// with the averaged level, the sample's own percent and an updated flag.
// A timed-out request is answered the cycle after it is taken (or once an
// older result has left), with the current level, sample percent 0 and
// updated low; nothing else changes.
// A good sample is clamped, scaled to percent, written into the history ring
// and the mean of the samples so far (all of the ring once it is full) is
// recomputed. Both divisions run on one shared 7-step restoring divider,
// so a good sample holds off new requests until its result is loaded;
// the result becomes valid in the same cycle as the next request can be taken.
// One request is in work at a time; the output register lets the next
// request in while a result still waits. A stalled receiver holds the
// result and blocks new requests once the finished one has nowhere to go.
// Reset: min_raw 0, max_raw 4095, level 100, ring empty. cfg writes take
// effect at once and are meant only while the block is idle.
`include "assert_macros.svh"

module battery_percent_averager_unit
    import bpa_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [11:0] adc_sample
    input  logic                 s_tuser,   // [0] timed_out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [6:0] level_percent, [13:7] sample_percent
    output logic                 m_tuser,   // [0] updated
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [RAW_W-1:0]     cfg_data
);

    cmd_t             cmd;
    sts_t             sts;
    logic [PCT_W-1:0] level;
    logic [PCT_W-1:0] sample_pct;

    bpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_timeout (s_tuser),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    bpa_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .sample_in   (s_tdata[RAW_W-1:0]),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_level   (level),
        .out_sample  (sample_pct),
        .out_updated (m_tuser)
    );

    assign m_tdata = {2'b00, sample_pct, level};

    `ASSERT_NEXT(a_busy_blocks_input, s_tvalid && s_tready && !s_tuser, !s_tready)
    `ASSERT_NEXT(a_timeout_answer, s_tvalid && s_tready && s_tuser && (!m_tvalid || m_tready), m_tvalid && !m_tuser)
    `ASSERT_IMPLY(a_level_range, m_tvalid, level <= PCT_FULL && sample_pct <= PCT_FULL)
    `ASSERT_IMPLY(a_timeout_zero_pct, m_tvalid && !m_tuser, sample_pct == '0)

endmodule
